[rtl/ffd_pkg.sv]
// Shared types, character codes and helpers for the form field extractor.
// No dependencies; imported by every module of the block.
package ffd_pkg;

  // Character codes seen in a form body
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Widest key the match logic holds
  localparam int unsigned MAX_KEY_BYTES = 8;
  localparam int unsigned KEY_W         = 8 * MAX_KEY_BYTES;

  // Status codes of the final result
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // Result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_TEXT    = 2'd0;
  localparam logic [1:0] REG_KEY_LENGTH  = 2'd1;
  localparam logic [1:0] REG_CAPACITY    = 2'd2;
  localparam logic [1:0] REG_VALUE_LIMIT = 2'd3;

  // Results one body byte can cause at most
  localparam int unsigned MAX_RESULTS = 4;

  typedef struct packed {
    logic [KEY_W-1:0] key_text;
    logic [3:0]       key_length;
    logic [6:0]       capacity;
    logic [7:0]       value_limit;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [1:0] status;
  } item_t;

  // All results caused by one body byte
  typedef struct packed {
    item_t [MAX_RESULTS-1:0] items;
    logic  [2:0]             count;
  } bundle_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

[rtl/ffd_cfg.sv]
// Configuration register file for the form field extractor.
// Depends on ffd_pkg for the register indexes and the cfg_t bundle.
module ffd_cfg
  import ffd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Take a register write on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_text    <= '0;
      cfg_r.key_length  <= 4'd4;
      cfg_r.capacity    <= 7'd32;
      cfg_r.value_limit <= 8'd160;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_TEXT:    cfg_r.key_text    <= cfg_data[KEY_W-1:0];
        REG_KEY_LENGTH:  cfg_r.key_length  <= cfg_data[3:0];
        REG_CAPACITY:    cfg_r.capacity    <= cfg_data[6:0];
        REG_VALUE_LIMIT: cfg_r.value_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/ffd_front.sv]
// Front end: scans body bytes, matches the key and decodes the value,
// turning each accepted byte into a bundle of results. Depends on ffd_pkg.
module ffd_front
  import ffd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_space,
  output logic       q_push,
  output bundle_t    q_bundle
);

  localparam logic [1:0] MODE_MATCH = 2'd0;
  localparam logic [1:0] MODE_SKIP  = 2'd1;
  localparam logic [1:0] MODE_VALUE = 2'd2;
  localparam logic [1:0] MODE_DONE  = 2'd3;

  logic [1:0] mode_r, mode_nxt;
  logic [3:0] kpos_r, kpos_nxt;
  logic [1:0] pcnt_r, pcnt_nxt;
  logic [7:0] phex_r, phex_nxt;
  logic [7:0] rlen_r, rlen_nxt;
  logic [6:0] dcnt_r, dcnt_nxt;
  logic       ovf_r, ovf_nxt;
  bundle_t    bundle_c;
  logic       accept;

  assign in_ready = q_space;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (bundle_c.count != 3'd0);
  assign q_bundle = bundle_c;

  // Work out the next scan state and the results of this byte
  always_comb begin : step_c
    logic [3:0] klen;
    logic [7:0] kc;
    logic [6:0] cap;
    logic [7:0] p [3];
    logic [1:0] np;
    logic       fin;
    logic       fin_use_ovf;
    logic [1:0] fin_code;
    logic       entered;
    logic       do_fresh;
    logic       do_flush;
    logic [2:0] ne;
    mode_nxt = mode_r;
    kpos_nxt = kpos_r;
    pcnt_nxt = pcnt_r;
    phex_nxt = phex_r;
    rlen_nxt = rlen_r;
    dcnt_nxt = dcnt_r;
    ovf_nxt  = ovf_r;
    klen     = (cfg.key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : cfg.key_length;
    kc       = cfg.key_text[{kpos_r[2:0], 3'b000} +: 8];
    cap      = (cfg.capacity == 7'd0) ? 7'd0 : cfg.capacity - 7'd1;
    p[0]     = '0;
    p[1]     = '0;
    p[2]     = '0;
    np       = '0;
    fin      = 1'b0;
    fin_use_ovf = 1'b0;
    fin_code = ST_OK;
    entered  = 1'b0;
    do_fresh = 1'b0;
    do_flush = 1'b0;
    ne       = '0;
    bundle_c = '0;

    unique case (mode_r)
      MODE_MATCH: begin
        if (in_byte == CH_AMP) begin
          kpos_nxt = '0;
        end else if (kpos_r < klen) begin
          if (in_byte == kc) begin
            kpos_nxt = kpos_r + 4'd1;
          end else begin
            mode_nxt = MODE_SKIP;
          end
        end else if (in_byte == CH_EQUALS) begin
          entered  = 1'b1;
          mode_nxt = MODE_VALUE;
          pcnt_nxt = '0;
          phex_nxt = '0;
          rlen_nxt = '0;
          dcnt_nxt = '0;
          ovf_nxt  = 1'b0;
        end else begin
          mode_nxt = MODE_SKIP;
        end
        if (entered) begin
          if (cfg.value_limit == 8'd0) begin
            fin      = 1'b1;
            fin_code = ST_TOO_LONG;
          end else if (in_last) begin
            fin      = 1'b1;
            fin_code = ST_OK;
          end
        end else if (in_last) begin
          fin      = 1'b1;
          fin_code = ST_NOT_FOUND;
        end
      end
      MODE_SKIP: begin
        if (in_byte == CH_AMP) begin
          mode_nxt = MODE_MATCH;
          kpos_nxt = '0;
        end
        if (in_last) begin
          fin      = 1'b1;
          fin_code = ST_NOT_FOUND;
        end
      end
      MODE_VALUE: begin
        if (in_byte == CH_AMP) begin
          do_flush    = 1'b1;
          fin         = 1'b1;
          fin_use_ovf = 1'b1;
        end else begin
          if (rlen_r != 8'hFF) begin
            rlen_nxt = rlen_r + 8'd1;
          end
          if (rlen_nxt >= cfg.value_limit) begin
            fin      = 1'b1;
            fin_code = ST_TOO_LONG;
          end else begin
            // Advance the escape decoder
            unique case (pcnt_r)
              2'd1: begin
                if (is_hex(in_byte)) begin
                  phex_nxt = in_byte;
                  pcnt_nxt = 2'd2;
                end else begin
                  pcnt_nxt = 2'd0;
                  p[np] = CH_PERCENT;
                  np    = np + 2'd1;
                  do_fresh = 1'b1;
                end
              end
              2'd2: begin
                pcnt_nxt = 2'd0;
                if (is_hex(in_byte)) begin
                  p[np] = {hex_val(phex_r), hex_val(in_byte)};
                  np    = np + 2'd1;
                end else begin
                  p[np] = CH_PERCENT;
                  np    = np + 2'd1;
                  p[np] = phex_r;
                  np    = np + 2'd1;
                  do_fresh = 1'b1;
                end
              end
              default: do_fresh = 1'b1;
            endcase
            if (do_fresh) begin
              if (in_byte == CH_PERCENT) begin
                pcnt_nxt = 2'd1;
              end else if (in_byte == CH_PLUS) begin
                p[np] = CH_SPACE;
                np    = np + 2'd1;
              end else begin
                p[np] = in_byte;
                np    = np + 2'd1;
              end
            end
            if (in_last) begin
              do_flush    = 1'b1;
              fin         = 1'b1;
              fin_use_ovf = 1'b1;
            end
          end
        end
      end
      default: begin
        if (in_last) begin
          mode_nxt = MODE_MATCH;
          kpos_nxt = '0;
          pcnt_nxt = '0;
        end
      end
    endcase

    // Replay a held escape literally at the end of the value
    if (do_flush) begin
      if (pcnt_nxt != 2'd0) begin
        p[np] = CH_PERCENT;
        np    = np + 2'd1;
      end
      if (pcnt_nxt == 2'd2) begin
        p[np] = phex_nxt;
        np    = np + 2'd1;
      end
      pcnt_nxt = '0;
    end

    // Emit decoded bytes that fit, note those that do not
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < np) begin
        if (dcnt_nxt < cap) begin
          bundle_c.items[ne[1:0]] = '{kind: KIND_BYTE, data: p[i], status: ST_OK};
          ne       = ne + 3'd1;
          dcnt_nxt = dcnt_nxt + 7'd1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end

    // Close the body with its status
    if (fin) begin
      if (fin_use_ovf) begin
        fin_code = ovf_nxt ? ST_OVERFLOW : ST_OK;
      end
      bundle_c.items[ne[1:0]] = '{kind: KIND_STATUS, data: 8'd0, status: fin_code};
      ne       = ne + 3'd1;
      pcnt_nxt = '0;
      kpos_nxt = '0;
      mode_nxt = in_last ? MODE_MATCH : MODE_DONE;
    end
    bundle_c.count = ne;
  end

  // Hold the scan state between accepted bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MATCH;
      kpos_r <= '0;
      pcnt_r <= '0;
      phex_r <= '0;
      rlen_r <= '0;
      dcnt_r <= '0;
      ovf_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      kpos_r <= kpos_nxt;
      pcnt_r <= pcnt_nxt;
      phex_r <= phex_nxt;
      rlen_r <= rlen_nxt;
      dcnt_r <= dcnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

[rtl/ffd_back.sv]
// Back end: queues result bundles and sends their items one per cycle while
// out_ready is high, through a registered output stage. Depends on ffd_pkg.
module ffd_back
  import ffd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_push,
  input  bundle_t    q_bundle,
  output logic       q_space,
  output logic       out_valid,
  input  logic       out_ready,
  output item_t      out_item,
  output logic       out_run_last
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  bundle_t            queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [1:0]         idx_r;
  logic               out_valid_r;
  item_t              out_item_r;
  logic               out_last_r;
  bundle_t            head;
  logic               load;
  logic               head_done;
  logic               pop;

  assign head      = queue_r[rd_ptr_r];
  assign q_space   = (count_r != CNT_W'(QUEUE_DEPTH));
  assign load      = (!out_valid_r || out_ready) && (count_r != '0);
  assign head_done = ({1'b0, idx_r} == head.count - 3'd1);
  assign pop       = load && head_done;

  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;
  assign out_run_last = out_last_r;

  // Write bundles into the queue
  always_ff @(posedge clk) begin
    if (q_push) begin
      queue_r[wr_ptr_r] <= q_bundle;
    end
  end

  // Advance pointers, occupancy and the item index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      idx_r    <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (q_push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !q_push) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (load) begin
        idx_r <= head_done ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  // Output register: load the next item or drop valid after a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= head.items[idx_r];
      out_last_r <= head_done;
    end
  end

endmodule

[rtl/form_field_extract_decode.sv]
// Top level of the form field extractor and percent decoder.
// Depends on ffd_pkg, ffd_cfg, ffd_front and ffd_back.
//
// Usage:
//   in_*  : one body byte per transfer (tdata = body byte, tlast = final byte).
//   out_* : one result per transfer; tuser = kind (0 decoded byte, 1 status),
//           tdata[7:0] = decoded byte, tdata[9:8] = status, tlast = last
//           result caused by one body byte.
//   cfg_* : register writes (0 key text, 1 key length, 2 capacity,
//           3 value limit), accepted every cycle; write only while idle.
// Throughput: one body byte per cycle on input while the bundle queue has
// space; one result per cycle on output while out_tready is high. A byte
// causing n results is sent as n output transfers, so the sustained input
// rate is set by the single output register draining the bundle queue.
// Path: with the queue empty, the first result of a byte is written into the
// bundle queue, then loaded into the output register, and presented.
// Bytes causing no result leave no trace on the output.
// Reset: all scan state clears and registers take their reset values.
// Stall: when out_tready is low the output holds, the bundle queue
// (QUEUE_DEPTH bytes' worth) fills, then in_tready falls.
module form_field_extract_decode
  import ffd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] body_byte
  input  logic        in_tlast,   // body_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [9:8] status, rest zero
  output logic        out_tuser,  // kind
  output logic        out_tlast,  // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t    cfg;
  bundle_t q_bundle;
  logic    q_push;
  logic    q_space;
  item_t   out_item;

  ffd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ffd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_space  (q_space),
    .q_push   (q_push),
    .q_bundle (q_bundle)
  );

  ffd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_push       (q_push),
    .q_bundle     (q_bundle),
    .q_space      (q_space),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_item     (out_item),
    .out_run_last (out_tlast)
  );

  assign out_tdata = {6'd0, out_item.status, out_item.data};
  assign out_tuser = out_item.kind;

endmodule
